// ===== design/ehd_pkg.sv =====
package ehd_pkg;

  // group size for grouped mode
  localparam int unsigned GROUP_SIZE = 8;
  localparam int unsigned CNT_W = 8;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SLOPE_W = SAMPLE_W + 1;
  localparam int unsigned THRESH_W = 15;
  localparam int unsigned TICKS_W = 8;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPED_MODE = 2'd2;
  localparam int unsigned CFG_DATA_W = THRESH_W;

  // configuration reset values
  localparam logic [THRESH_W-1:0] THRESHOLD_RST = '0;
  localparam logic [TICKS_W-1:0] HOLDOFF_TICKS_RST = 8'd100;
  localparam logic GROUPED_MODE_RST = 1'b1;

  // item kinds
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // output stream packing
  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    logic [THRESH_W-1:0] threshold;
    logic [TICKS_W-1:0]  holdoff_ticks;
    logic                grouped_mode;
  } cfg_t;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] extremum_value;
    logic                       extremum_valid;
    logic                       holdoff_active;
    logic                       timer_restart;
  } result_t;

endpackage

// ===== design/extremum_detector_holdoff_top.sv =====
// channel | dir | tdata (low bit up)                          | tuser
// in_     | in  | sample[15:0]                                | command
// out_    | out | extremum_value[15:0], holdoff_active,       | extremum_valid
//         |     | timer_restart, zero fill to 24 bits         |
// cfg_    | in  | cfg_we, cfg_index (2 bits), cfg_wdata (15)  | -
//
// one transaction per cycle sustained while out_tready stays high; each item
// passes through the input register and then leaves through the result register
// rst_n is synchronous and active low; configuration returns to its defaults
// an item still waits in the input register while a result is held by a
// stalled out_tready, so one extra transaction is taken during a stall
module extremum_detector_holdoff_top
  import ehd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // sample stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // sample
  input  logic                  in_tuser,   // command
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // extremum_value, holdoff_active, timer_restart
  output logic                  out_tuser,  // extremum_valid
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  logic    in_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  result_t res_r;
  result_t res;
  logic    advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold     <= THRESHOLD_RST;
      cfg_r.holdoff_ticks <= HOLDOFF_TICKS_RST;
      cfg_r.grouped_mode  <= GROUPED_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:     cfg_r.threshold     <= cfg_wdata[THRESH_W-1:0];
        CFG_HOLDOFF_TICKS: cfg_r.holdoff_ticks <= cfg_wdata[TICKS_W-1:0];
        CFG_GROUPED_MODE:  cfg_r.grouped_mode  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake: input stage moves on when the result register frees up
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.command <= in_tuser;
      item_r.sample  <= in_tdata;
    end
  end

  ehd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .item  (item_r),
    .fire  (advance),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, res_r.timer_restart, res_r.holdoff_active,
                       res_r.extremum_value};
  assign out_tuser  = res_r.extremum_valid;

endmodule

// ===== design/ehd_core.sv =====
module ehd_core
  import ehd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    fire,
  output result_t res
);

  // detector state
  logic signed [SAMPLE_W-1:0] prev_sample_r, prev_sample_nxt;
  logic signed [SLOPE_W-1:0]  prev_slope_r, prev_slope_nxt;
  logic [CNT_W-1:0]           group_count_r, group_count_nxt;
  logic signed [SAMPLE_W-1:0] group_max_r, group_max_nxt;
  logic                       holdoff_flag_r, holdoff_flag_nxt;
  logic [TICKS_W-1:0]         holdoff_count_r, holdoff_count_nxt;

  logic signed [SLOPE_W-1:0] s_ext;
  logic signed [SLOPE_W-1:0] slope;
  logic [SLOPE_W-1:0]        mag;
  logic                      above;
  logic                      prev_pos, prev_neg, cur_pos, cur_neg;
  logic                      turn;
  logic                      emit;
  logic signed [SAMPLE_W-1:0] emit_value;

  // magnitude, slope and sign change
  always_comb begin
    s_ext    = {item.sample[SAMPLE_W-1], item.sample};
    mag      = s_ext[SLOPE_W-1] ? 17'(-s_ext) : 17'(s_ext);
    above    = mag > {2'b00, cfg.threshold};
    slope    = {prev_sample_r[SAMPLE_W-1], prev_sample_r} - s_ext;
    prev_pos = ~prev_slope_r[SLOPE_W-1] & (|prev_slope_r);
    prev_neg = prev_slope_r[SLOPE_W-1];
    cur_pos  = ~slope[SLOPE_W-1] & (|slope);
    cur_neg  = slope[SLOPE_W-1];
    turn     = (prev_pos & cur_neg) | (prev_neg & cur_pos);
  end

  // next state and result
  always_comb begin
    prev_sample_nxt   = prev_sample_r;
    prev_slope_nxt    = prev_slope_r;
    group_count_nxt   = group_count_r;
    group_max_nxt     = group_max_r;
    holdoff_flag_nxt  = holdoff_flag_r;
    holdoff_count_nxt = holdoff_count_r;
    emit              = 1'b0;
    emit_value        = '0;

    if (item.command == CMD_TICK) begin
      if (holdoff_flag_r) begin
        if (holdoff_count_r <= 8'd1) begin
          holdoff_flag_nxt  = 1'b0;
          holdoff_count_nxt = '0;
        end else begin
          holdoff_count_nxt = holdoff_count_r - 8'd1;
        end
      end
    end else if (above) begin
      if (turn) begin
        if (!cfg.grouped_mode) begin
          emit       = 1'b1;
          emit_value = item.sample;
        end else if (group_count_r < CNT_W'(GROUP_SIZE)) begin
          if (item.sample > group_max_r) begin
            group_max_nxt = item.sample;
          end
          group_count_nxt = group_count_r + 8'd1;
        end else begin
          // group max starts at zero and only rises, so it is never negative
          emit            = 1'b1;
          emit_value      = group_max_r;
          group_count_nxt = '0;
          group_max_nxt   = '0;
        end
        // emission while holdoff runs leaves the count alone
        if (emit && !holdoff_flag_r) begin
          holdoff_flag_nxt  = 1'b1;
          holdoff_count_nxt = (cfg.holdoff_ticks != '0) ? cfg.holdoff_ticks : 8'd1;
        end
      end
      prev_sample_nxt = item.sample;
      prev_slope_nxt  = slope;
    end

    res.extremum_value = emit_value;
    res.extremum_valid = emit;
    res.holdoff_active = holdoff_flag_nxt;
    res.timer_restart  = emit;
  end

  // state registers, updated once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r   <= '0;
      prev_slope_r    <= '0;
      group_count_r   <= '0;
      group_max_r     <= '0;
      holdoff_flag_r  <= 1'b0;
      holdoff_count_r <= '0;
    end else if (fire) begin
      prev_sample_r   <= prev_sample_nxt;
      prev_slope_r    <= prev_slope_nxt;
      group_count_r   <= group_count_nxt;
      group_max_r     <= group_max_nxt;
      holdoff_flag_r  <= holdoff_flag_nxt;
      holdoff_count_r <= holdoff_count_nxt;
    end
  end

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ehd_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 217;
  localparam int TICK_MARK = 100000;

  // expected-output tracker: mirrors the detector state and queues outputs
  class peak_tracker;
    cfg_t                 settings;
    logic signed [15:0]   last_sample;
    logic signed [16:0]   last_slope;
    logic [7:0]           group_cnt;
    logic signed [15:0]   group_peak;
    bit                   holdoff_on;
    logic [7:0]           holdoff_left;
    result_t              awaited[$];
    int                   errors;
    int                   n_results;
    int                   n_emissions;

    function new();
      settings.threshold = THRESHOLD_RST;
      settings.holdoff_ticks = HOLDOFF_TICKS_RST;
      settings.grouped_mode = GROUPED_MODE_RST;
      last_sample = '0;
      last_slope = '0;
      group_cnt = '0;
      group_peak = '0;
      holdoff_on = 1'b0;
      holdoff_left = '0;
      errors = 0;
      n_results = 0;
      n_emissions = 0;
    endfunction

    // advance the mirrored state by one accepted item
    function void note_item(item_t it);
      int      s;
      int      mag;
      int      slope;
      bit      turn;
      result_t r;
      r = '0;
      if (it.command == CMD_TICK) begin
        if (holdoff_on) begin
          if (holdoff_left <= 1) begin
            holdoff_on = 1'b0;
            holdoff_left = '0;
          end else begin
            holdoff_left = holdoff_left - 8'd1;
          end
        end
      end else begin
        s = int'($signed(it.sample));
        mag = (s < 0) ? -s : s;
        if (mag > int'(settings.threshold)) begin
          slope = int'(last_sample) - s;
          turn = (last_slope > 0 && slope < 0) || (last_slope < 0 && slope > 0);
          if (turn) begin
            if (!settings.grouped_mode) begin
              r.extremum_valid = 1'b1;
              r.extremum_value = s[15:0];
            end else if (group_cnt < GROUP_SIZE) begin
              if (s > int'(group_peak)) group_peak = s[15:0];
              group_cnt = group_cnt + 8'd1;
            end else begin
              // group full: this turn is dropped, the running peak goes out
              r.extremum_valid = 1'b1;
              r.extremum_value = group_peak;
              group_cnt = '0;
              group_peak = '0;
            end
            // a running holdoff is not reloaded
            if (r.extremum_valid && !holdoff_on) begin
              holdoff_left = (settings.holdoff_ticks == 0) ? 8'd1 : settings.holdoff_ticks;
              holdoff_on = 1'b1;
            end
          end
          last_sample = s[15:0];
          last_slope = slope[16:0];
        end
      end
      r.timer_restart = r.extremum_valid;
      r.holdoff_active = holdoff_on;
      awaited.push_back(r);
    endfunction

    // compare one output transaction with the oldest expectation
    function void check_output(result_t got);
      result_t want;
      n_results++;
      if (awaited.size() == 0) begin
        $error("output transaction with nothing expected");
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (want.extremum_valid) n_emissions++;
      if (got.extremum_value !== want.extremum_value) begin
        $error("extremum_value expected %0d got %0d",
               want.extremum_value, got.extremum_value);
        errors++;
      end
      if (got.extremum_valid !== want.extremum_valid) begin
        $error("extremum_valid expected %0d got %0d",
               want.extremum_valid, got.extremum_valid);
        errors++;
      end
      if (got.holdoff_active !== want.holdoff_active) begin
        $error("holdoff_active expected %0d got %0d",
               want.holdoff_active, got.holdoff_active);
        errors++;
      end
      if (got.timer_restart !== want.timer_restart) begin
        $error("timer_restart expected %0d got %0d",
               want.timer_restart, got.timer_restart);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata;   // sample
  logic                  in_tuser;   // command
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // extremum_value, holdoff_active, timer_restart
  logic                  out_tuser;  // extremum_valid
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  peak_tracker sb = new();

  int send_idle;
  int recv_idle;
  int cur_threshold;
  int walk_pos;
  int walk_dir;
  int n_items;
  int quiet_cycles = 0;
  result_t seen;

  extremum_detector_holdoff_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: check accepted outputs, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.extremum_value = out_tdata[15:0];
        seen.holdoff_active = out_tdata[16];
        seen.timer_restart = out_tdata[17];
        seen.extremum_valid = out_tuser;
        sb.check_output(seen);
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("** extremum_detector_holdoff_top: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // send one item, with random gaps before it
  task automatic push_item(logic cmd, logic signed [15:0] smp);
    item_t it;
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= smp;
    do @(posedge clk); while (!in_tready);
    it.command = cmd;
    it.sample = smp;
    sb.note_item(it);
    n_items++;
  endtask

  // stop sending and wait until every expected output is back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all three registers while the block is idle
  task automatic write_settings(int th, int ticks, int grp);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= th[14:0];
    @(posedge clk);
    cfg_index <= CFG_HOLDOFF_TICKS;
    cfg_wdata <= CFG_DATA_W'(ticks[7:0]);
    @(posedge clk);
    cfg_index <= CFG_GROUPED_MODE;
    cfg_wdata <= CFG_DATA_W'(grp[0]);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.settings.threshold = th[14:0];
    sb.settings.holdoff_ticks = ticks[7:0];
    sb.settings.grouped_mode = grp[0];
    cur_threshold = th;
  endtask

  // random sample: alternating swings above threshold, plus walk steps, repeats, corner values and noise
  function automatic int next_sample();
    int                 pick;
    int                 s;
    int                 mag;
    logic signed [15:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      raw = 16'($urandom);
      s = int'(raw);
    end else if (pick < 25) begin
      case ($urandom_range(0, 6))
        0: s = -32768;
        1: s = 32767;
        2: s = 0;
        3: s = -1;
        4: s = cur_threshold;
        5: s = cur_threshold + 1;
        default: s = -(cur_threshold + 1);
      endcase
    end else if (pick < 33) begin
      // repeated value gives a flat slope
      s = walk_pos;
    end else if (pick < 75) begin
      if ($urandom_range(0, 99) < 75) walk_dir = -walk_dir;
      mag = cur_threshold + 1 + $urandom_range(0, 32767 - cur_threshold);
      s = (walk_dir > 0) ? mag : -mag;
    end else begin
      if ($urandom_range(0, 9) < 6) walk_dir = -walk_dir;
      s = walk_pos + walk_dir * $urandom_range(1, 12000);
    end
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    walk_pos = s;
    return s;
  endfunction

  // stimulus
  initial begin
    int directed_a[] = '{TICK_MARK, 0, 32767, -32768, -32768, 32767, -32768, 32767,
                         -32768, 32767, -32768, 32767, -32768, 32767, -32768,
                         TICK_MARK};
    int directed_b[] = '{1000, 1001, -1001, 1001, -1001, TICK_MARK, TICK_MARK};
    int th;
    int ticks;
    int grp;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= CMD_SAMPLE;
    cfg_we <= 1'b0;
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= '0;
    send_idle = 22;
    recv_idle = 52;
    cur_threshold = 0;
    walk_pos = 0;
    walk_dir = 1;
    n_items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults after reset, extremes, flat slope, full group
    foreach (directed_a[k]) begin
      if (directed_a[k] == TICK_MARK) push_item(CMD_TICK, 16'sd0);
      else push_item(CMD_SAMPLE, 16'(directed_a[k]));
    end
    drain();
    // directed: threshold boundary, single mode, zero holdoff count
    write_settings(1000, 0, 0);
    foreach (directed_b[k]) begin
      if (directed_b[k] == TICK_MARK) push_item(CMD_TICK, 16'sd0);
      else push_item(CMD_SAMPLE, 16'(directed_b[k]));
    end
    drain();

    // random phases over settings and idle patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p / 3)
        0: begin send_idle = 22; recv_idle = 52; end
        1: begin send_idle = 52; recv_idle = 22; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (p)
        0: begin th = 0;     ticks = 1;   grp = 0; end
        1: begin th = 32767; ticks = 255; grp = 1; end
        2: begin th = $urandom_range(0, 3000); ticks = 0; grp = 1; end
        3: begin th = $urandom_range(0, 8000); ticks = $urandom_range(1, 20); grp = 0; end
        4: begin th = 0;     ticks = 255; grp = 1; end
        5: begin
          th = $urandom_range(0, 32767);
          ticks = $urandom_range(1, 255);
          grp = $urandom_range(0, 1);
        end
        6: begin th = 100;   ticks = 5;   grp = 1; end
        7: begin th = $urandom_range(0, 2000); ticks = 1; grp = 0; end
        default: begin th = 1; ticks = 3; grp = 1; end
      endcase
      write_settings(th, ticks, grp);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 35) push_item(CMD_TICK, 16'($urandom));
        else push_item(CMD_SAMPLE, 16'(next_sample()));
      end
      drain();
    end

    // final wait for anything still in flight
    repeat (8) @(posedge clk);
    $display("covered %0d items over %0d settings, %0d outputs, %0d emissions",
             n_items, PHASES + 2, sb.n_results, sb.n_emissions);
    if (sb.awaited.size() != 0) begin
      $error("%0d expected outputs never arrived", sb.awaited.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("** extremum_detector_holdoff_top: PASSED **");
    end else begin
      $display("** extremum_detector_holdoff_top: FAILED **");
    end
    $finish;
  end

endmodule
